// ===== src/mac_learning_forwarder_unit_macros.svh =====
`ifndef MAC_LEARNING_FORWARDER_UNIT_MACROS_SVH
`define MAC_LEARNING_FORWARDER_UNIT_MACROS_SVH

// same-cycle implication
`define MLF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MLF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mlf_pkg.sv =====
package mlf_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int PORT_COUNT  = 8;

   localparam int IDX_W     = $clog2(TABLE_DEPTH);
   localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int MAC_W     = 48;
   localparam int PORT_W    = 3;
   localparam int MASK_W    = 8;
   localparam int LEN_W     = 11;
   localparam int VERDICT_W = 2;

   localparam logic [LEN_W-1:0] HEADER_BYTES = LEN_W'(14);
   localparam logic [MAC_W-1:0] BCAST_MAC    = {MAC_W{1'b1}};

   localparam logic [MASK_W-1:0] PORT_LIMIT =
      (PORT_COUNT >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << PORT_COUNT) - 64'd1);

   localparam logic [VERDICT_W-1:0] VERDICT_UNICAST = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_FLOOD   = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_SHORT   = 2'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic [PORT_W-1:0] port;
   } mlf_entry_type;

   typedef struct packed {
      logic load;
      logic scan_clear;
      logic scan;
      logic finish;
   } mlf_cmd_type;

   typedef struct packed {
      logic is_short;
      logic scan_done;
   } mlf_stat_type;

   function automatic logic [MASK_W-1:0] port_onehot(input logic [PORT_W-1:0] p);
      logic [MASK_W-1:0] m;
      m = MASK_W'(1) << p;
      return m;
   endfunction

endpackage

// ===== src/mlf_datapath.sv =====
`include "mac_learning_forwarder_unit_macros.svh"

module mlf_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  mlf_pkg::mlf_cmd_type             cmd_i,
   output mlf_pkg::mlf_stat_type            stat_o,
   input  logic [mlf_pkg::PORT_W-1:0]       req_ingress_port,
   input  logic [mlf_pkg::MAC_W-1:0]        req_src_mac,
   input  logic [mlf_pkg::MAC_W-1:0]        req_dst_mac,
   input  logic [mlf_pkg::LEN_W-1:0]        req_frame_length,
   input  logic                             csr_valid,
   input  logic [mlf_pkg::MASK_W-1:0]       csr_port_present,
   output logic [mlf_pkg::MASK_W-1:0]       rsp_forward_mask,
   output logic [mlf_pkg::VERDICT_W-1:0]    rsp_verdict,
   output logic                             rsp_learned,
   output logic                             rsp_table_full
);
   import mlf_pkg::*;

   mlf_entry_type table_mem [TABLE_DEPTH];

   logic [PORT_W-1:0]    ingress_ff, ingress_in;
   logic [MAC_W-1:0]     src_ff, src_in;
   logic [MAC_W-1:0]     dst_ff, dst_in;
   logic [LEN_W-1:0]     flen_ff, flen_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic [CNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   mlf_entry_type        rd_data_ff;
   logic                 dst_hit_ff, dst_hit_in;
   logic [PORT_W-1:0]    dst_port_ff, dst_port_in;
   logic                 src_hit_ff, src_hit_in;
   logic [MASK_W-1:0]    present_ff, present_in;
   logic [MASK_W-1:0]    rsp_mask_ff, rsp_mask_in;
   logic [VERDICT_W-1:0] rsp_verdict_ff, rsp_verdict_in;
   logic                 rsp_learned_ff, rsp_learned_in;
   logic                 rsp_full_ff, rsp_full_in;

   logic                 rd_en;
   logic                 is_short;
   logic                 need_learn;
   logic                 learn_now;
   logic                 full_now;

   assign is_short   = flen_ff < HEADER_BYTES;
   assign need_learn = !is_short && (src_ff != BCAST_MAC) && !src_hit_ff;
   assign learn_now  = need_learn && (used_ff != CNT_W'(TABLE_DEPTH));
   assign full_now   = need_learn && (used_ff == CNT_W'(TABLE_DEPTH));

   always_comb begin
      ingress_in = ingress_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      flen_in    = flen_ff;
      if (cmd_i.load) begin
         ingress_in = req_ingress_port;
         src_in     = req_src_mac;
         dst_in     = req_dst_mac;
         flen_in    = req_frame_length;
      end

      rd_idx_in  = rd_idx_ff;
      cmp_vld_in = 1'b0;
      rd_en      = 1'b0;
      if (cmd_i.scan_clear) begin
         rd_idx_in = '0;
      end else if (cmd_i.scan && (rd_idx_ff != used_ff)) begin
         rd_en      = 1'b1;
         rd_idx_in  = rd_idx_ff + 1'b1;
         cmp_vld_in = 1'b1;
      end

      dst_hit_in  = dst_hit_ff;
      dst_port_in = dst_port_ff;
      src_hit_in  = src_hit_ff;
      if (cmd_i.scan_clear) begin
         dst_hit_in = 1'b0;
         src_hit_in = 1'b0;
      end else if (cmp_vld_ff) begin
         if ((rd_data_ff.mac == dst_ff) && !dst_hit_ff) begin
            dst_hit_in  = 1'b1;
            dst_port_in = rd_data_ff.port;
         end
         if (rd_data_ff.mac == src_ff) begin
            src_hit_in = 1'b1;
         end
      end

      present_in = present_ff;
      if (csr_valid) begin
         present_in = csr_port_present;
      end

      used_in        = used_ff;
      rsp_mask_in    = rsp_mask_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_learned_in = rsp_learned_ff;
      rsp_full_in    = rsp_full_ff;
      if (cmd_i.finish) begin
         rsp_learned_in = learn_now;
         rsp_full_in    = full_now;
         if (learn_now) begin
            used_in = used_ff + 1'b1;
         end
         if (is_short) begin
            rsp_mask_in    = '0;
            rsp_verdict_in = VERDICT_SHORT;
         end else if (dst_ff == BCAST_MAC) begin
            rsp_mask_in    = present_ff & ~port_onehot(ingress_ff) & PORT_LIMIT;
            rsp_verdict_in = VERDICT_FLOOD;
         end else if (dst_hit_ff && (dst_port_ff != ingress_ff)) begin
            rsp_mask_in    = port_onehot(dst_port_ff);
            rsp_verdict_in = VERDICT_UNICAST;
         end else begin
            rsp_mask_in    = '0;
            rsp_verdict_in = VERDICT_UNKNOWN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_idx_ff[IDX_W-1:0]];
      end
      if (cmd_i.finish && learn_now) begin
         table_mem[used_ff[IDX_W-1:0]] <= '{mac: src_ff, port: ingress_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         rd_idx_ff  <= '0;
         cmp_vld_ff <= 1'b0;
         present_ff <= {MASK_W{1'b1}};
      end else begin
         used_ff    <= used_in;
         rd_idx_ff  <= rd_idx_in;
         cmp_vld_ff <= cmp_vld_in;
         present_ff <= present_in;
      end
      ingress_ff     <= ingress_in;
      src_ff         <= src_in;
      dst_ff         <= dst_in;
      flen_ff        <= flen_in;
      dst_hit_ff     <= dst_hit_in;
      dst_port_ff    <= dst_port_in;
      src_hit_ff     <= src_hit_in;
      rsp_mask_ff    <= rsp_mask_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_learned_ff <= rsp_learned_in;
      rsp_full_ff    <= rsp_full_in;
   end

   assign stat_o.is_short  = is_short;
   assign stat_o.scan_done = (rd_idx_ff == used_ff) && !cmp_vld_ff;

   assign rsp_forward_mask = rsp_mask_ff;
   assign rsp_verdict      = rsp_verdict_ff;
   assign rsp_learned      = rsp_learned_ff;
   assign rsp_table_full   = rsp_full_ff;

   `MLF_ASSERT_IMP(a_used_bound, clock, reset, 1'b1, used_ff <= CNT_W'(TABLE_DEPTH), "fill count past table depth")
   `MLF_ASSERT_IMP(a_idx_bound, clock, reset, 1'b1, rd_idx_ff <= used_ff, "scan index past fill count")
   `MLF_ASSERT_NEXT(a_learn_count, clock, reset, cmd_i.finish && learn_now, used_ff == $past(used_ff) + 1'b1, "learn did not bump fill count")
   `MLF_ASSERT_IMP(a_learn_full, clock, reset, cmd_i.finish, !(learn_now && full_now), "learned and table full together")

endmodule

// ===== src/mlf_ctrl.sv =====
module mlf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  mlf_pkg::mlf_stat_type stat_i,
   output mlf_pkg::mlf_cmd_type  cmd_o
);
   import mlf_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CHECK  = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd_o    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_o.load = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd_o.scan_clear = 1'b1;
            state_in         = stat_i.is_short ? ST_FINISH : ST_SCAN;
         end
         ST_SCAN: begin
            cmd_o.scan = 1'b1;
            if (stat_i.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd_o.finish = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd_o.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/mac_learning_forwarder_unit.sv =====
// Learning bridge lookup: one frame header in, one forwarding decision out. The MAC table
// lives in a single-port-read memory filled in arrival order, so no clearing pass is needed
// after reset. Each header is resolved by a table scan that reads one entry per cycle over
// the used entries (a short frame skips the scan), and the final step is held while the
// previous result still waits on rsp_ready. The next header may be taken while the
// previous result still waits on rsp_ready.
module mac_learning_forwarder_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [mlf_pkg::PORT_W-1:0]       req_ingress_port,
   input  logic [mlf_pkg::MAC_W-1:0]        req_src_mac,
   input  logic [mlf_pkg::MAC_W-1:0]        req_dst_mac,
   input  logic [mlf_pkg::LEN_W-1:0]        req_frame_length,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mlf_pkg::MASK_W-1:0]       rsp_forward_mask,
   output logic [mlf_pkg::VERDICT_W-1:0]    rsp_verdict,
   output logic                             rsp_learned,
   output logic                             rsp_table_full,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mlf_pkg::MASK_W-1:0]       csr_port_present
);
   import mlf_pkg::*;

   mlf_cmd_type  cmd;
   mlf_stat_type stat;

   assign csr_ready = 1'b1;

   mlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat_i    (stat),
      .cmd_o     (cmd)
   );

   mlf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd_i            (cmd),
      .stat_o           (stat),
      .req_ingress_port (req_ingress_port),
      .req_src_mac      (req_src_mac),
      .req_dst_mac      (req_dst_mac),
      .req_frame_length (req_frame_length),
      .csr_valid        (csr_valid),
      .csr_port_present (csr_port_present),
      .rsp_forward_mask (rsp_forward_mask),
      .rsp_verdict      (rsp_verdict),
      .rsp_learned      (rsp_learned),
      .rsp_table_full   (rsp_table_full)
   );

endmodule

// ===== bench/mac_learning_forwarder_unit_tb.sv =====
`timescale 1ns / 100ps

module mac_learning_forwarder_unit_tb;
   import mlf_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 218;
   localparam int POOL_SIZE = 72;
   localparam int HOLD_OFF = 400;
   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      logic [PORT_W-1:0] ingress_port;
      logic [MAC_W-1:0]  src_mac;
      logic [MAC_W-1:0]  dst_mac;
      logic [LEN_W-1:0]  frame_length;
   } header_type;

   typedef struct packed {
      logic [MASK_W-1:0]    forward_mask;
      logic [VERDICT_W-1:0] verdict;
      logic                 learned;
      logic                 table_full;
   } decision_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [PORT_W-1:0] req_ingress_port = '0;
   logic [MAC_W-1:0] req_src_mac = '0;
   logic [MAC_W-1:0] req_dst_mac = '0;
   logic [LEN_W-1:0] req_frame_length = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [MASK_W-1:0] rsp_forward_mask;
   logic [VERDICT_W-1:0] rsp_verdict;
   logic rsp_learned;
   logic rsp_table_full;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [MASK_W-1:0] csr_port_present = '0;

   mac_learning_forwarder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ingress_port (req_ingress_port),
      .req_src_mac      (req_src_mac),
      .req_dst_mac      (req_dst_mac),
      .req_frame_length (req_frame_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_forward_mask (rsp_forward_mask),
      .rsp_verdict      (rsp_verdict),
      .rsp_learned      (rsp_learned),
      .rsp_table_full   (rsp_table_full),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_port_present (csr_port_present)
   );

   always #6 clock = ~clock;

   // bridge table mirror
   logic [MAC_W-1:0]  tbl_mac [TABLE_DEPTH];
   logic [PORT_W-1:0] tbl_port [TABLE_DEPTH];
   logic              tbl_valid [TABLE_DEPTH];
   int                mac_count = 0;
   logic [MASK_W-1:0] port_cfg = 8'hFF;

   header_type   pending [$];
   decision_type decision_q [$];
   logic [MAC_W-1:0] mac_pool [POOL_SIZE];

   bit req_fire = 1'b0;
   bit idle_on = 1'b1;
   bit hold_request = 1'b0;
   int req_gap = 0;
   int stall_cycles = 0;
   int hold_cycles = 0;
   int pushed_total = 0;
   int accepted_total = 0;
   int errors = 0;
   int cycle_count = 0;

   function automatic int find_slot(logic [MAC_W-1:0] mac);
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         if (tbl_valid[k] && tbl_mac[k] == mac) return k;
      end
      return -1;
   endfunction

   function automatic decision_type forward_decision(header_type h);
      decision_type d;
      int dst_slot;
      d = '0;
      if (h.frame_length < HEADER_BYTES) begin
         d.verdict = VERDICT_SHORT;
         return d;
      end
      // destination is resolved before the source is learned
      dst_slot = find_slot(h.dst_mac);
      if (h.src_mac != BCAST_MAC && find_slot(h.src_mac) < 0) begin
         if (mac_count < TABLE_DEPTH) begin
            tbl_mac[mac_count] = h.src_mac;
            tbl_port[mac_count] = h.ingress_port;
            tbl_valid[mac_count] = 1'b1;
            mac_count++;
            d.learned = 1'b1;
         end else begin
            d.table_full = 1'b1;
         end
      end
      if (h.dst_mac == BCAST_MAC) begin
         d.forward_mask = port_cfg & ~(MASK_W'(1) << h.ingress_port) & PORT_LIMIT;
         d.verdict = VERDICT_FLOOD;
      end else if (dst_slot >= 0 && tbl_port[dst_slot] != h.ingress_port) begin
         d.forward_mask = MASK_W'(1) << tbl_port[dst_slot];
         d.verdict = VERDICT_UNICAST;
      end else begin
         d.verdict = VERDICT_UNKNOWN;
      end
      return d;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   function automatic logic [MAC_W-1:0] rand_mac();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[MAC_W-1:0];
   endfunction

   function automatic header_type make_header(logic [PORT_W-1:0] port, logic [MAC_W-1:0] src,
                                              logic [MAC_W-1:0] dst, logic [LEN_W-1:0] len);
      header_type h;
      h.ingress_port = port;
      h.src_mac = src;
      h.dst_mac = dst;
      h.frame_length = len;
      return h;
   endfunction

   function automatic header_type random_header();
      header_type h;
      int pick;
      h.ingress_port = PORT_W'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 70) h.src_mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 80) h.src_mac = BCAST_MAC;
      else h.src_mac = rand_mac();
      pick = $urandom_range(0, 99);
      if (pick < 50) h.dst_mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 75) h.dst_mac = BCAST_MAC;
      else if (pick < 80) h.dst_mac = h.src_mac;
      else h.dst_mac = rand_mac();
      pick = $urandom_range(0, 99);
      if (pick < 10) h.frame_length = LEN_W'($urandom_range(0, 13));
      else if (pick < 15) h.frame_length = LEN_W'(14);
      else if (pick < 20) h.frame_length = LEN_W'(2047);
      else h.frame_length = LEN_W'($urandom_range(14, 2047));
      return h;
   endfunction

   task automatic write_port_present(logic [MASK_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_port_present <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (accepted_total != pushed_total || decision_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic queue_header(header_type h);
      pending.push_back(h);
      pushed_total++;
   endtask

   // request driver
   always @(negedge clock) begin
      header_type h;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(0, 7);
            req_valid <= 1'b0;
         end else if (pending.size() > 0) begin
            h = pending.pop_front();
            req_ingress_port <= h.ingress_port;
            req_src_mac <= h.src_mac;
            req_dst_mac <= h.dst_mac;
            req_frame_length <= h.frame_length;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response sink
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_cycles = HOLD_OFF - 1;
         rsp_ready <= 1'b0;
      end else if (stall_cycles > 0) begin
         stall_cycles--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_cycles = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // transfer monitor and checker
   always @(posedge clock) begin
      decision_type want;
      req_fire = !reset && req_valid && req_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) port_cfg = csr_port_present;
         if (req_fire) begin
            decision_q.push_back(forward_decision(make_header(req_ingress_port, req_src_mac,
                                                              req_dst_mac, req_frame_length)));
            accepted_total++;
         end
         if (rsp_valid && rsp_ready) begin
            if (decision_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual mask %0h verdict %0d",
                        $time, rsp_forward_mask, rsp_verdict);
               errors++;
            end else begin
               want = decision_q.pop_front();
               check_field("forward_mask", 64'(want.forward_mask), 64'(rsp_forward_mask));
               check_field("verdict", 64'(want.verdict), 64'(rsp_verdict));
               check_field("learned", 64'(want.learned), 64'(rsp_learned));
               check_field("table_full", 64'(want.table_full), 64'(rsp_table_full));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, decision_q.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic [MAC_W-1:0] mac_a, mac_b, mac_c, mac_d, mac_e;
      logic [MASK_W-1:0] cfg_values [PHASES];
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         tbl_mac[k] = '0;
         tbl_port[k] = '0;
         tbl_valid[k] = 1'b0;
      end
      for (int k = 0; k < POOL_SIZE; k++) mac_pool[k] = rand_mac();
      mac_a = 48'h02AA_0000_0001;
      mac_b = 48'h02AA_0000_0002;
      mac_c = 48'h02AA_0000_0003;
      mac_d = 48'h02AA_0000_0004;
      mac_e = 48'h02AA_0000_0005;
      cfg_values = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hA5,
                     MASK_W'($urandom), MASK_W'($urandom), 8'h7E};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: short frames, learning, unicast and broadcast, all with the reset value of port_present
      queue_header(make_header(3'd0, mac_a, mac_b, 11'd0));
      queue_header(make_header(3'd7, mac_a, mac_b, 11'd13));
      queue_header(make_header(3'd1, mac_a, mac_a, 11'd14));
      queue_header(make_header(3'd2, mac_b, mac_a, 11'd2047));
      queue_header(make_header(3'd1, mac_a, mac_b, 11'd64));
      queue_header(make_header(3'd5, mac_a, mac_b, 11'd64));
      queue_header(make_header(3'd1, mac_c, mac_a, 11'd100));
      queue_header(make_header(3'd3, mac_d, BCAST_MAC, 11'd14));
      queue_header(make_header(3'd0, BCAST_MAC, BCAST_MAC, 11'd60));
      queue_header(make_header(3'd7, BCAST_MAC, mac_a, 11'd60));
      queue_header(make_header(3'd0, '0, '0, 11'd14));
      queue_header(make_header(3'd6, 48'hFFFF_FFFF_FFFE, '0, 11'd1500));
      queue_header(make_header(3'd4, mac_e, rand_mac(), 11'd1024));
      queue_header(make_header(3'd7, mac_e, 48'hFFFF_FFFF_FFFE, 11'd13));
      queue_header(make_header(3'd5, mac_d, BCAST_MAC, 11'd2047));
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         write_port_present(cfg_values[p]);
         @(posedge clock);
         if (p == 2) hold_request = 1'b1;
         if (p == PHASES - 1) idle_on = 1'b0;
         for (int i = 0; i < PHASE_ITEMS; i++) queue_header(random_header());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
